>>> sv/htse_pkg.sv
// Shared types and constants of the harmonic tone synthesiser with envelope.
package htse_pkg;

  localparam int STEP_W     = 23;
  localparam int POS_W      = 21;
  localparam int TDATA_W    = 72;
  localparam int SAMPLE_W   = 16;
  localparam int VOL_W      = 7;
  localparam int RAMP_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int MUL_W      = 32;
  localparam int FADE_SPAN  = 49152;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LEN = 2'd2;

  localparam logic [VOL_W-1:0]  VOL_RESET  = 7'd60;
  localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd100;
  localparam logic [RAMP_W-1:0] RAMP_RESET = 10'd110;

  localparam logic [16:0] POLY_A     = 17'd102944;
  localparam logic [16:0] POLY_B     = 17'd42048;
  localparam logic [16:0] POLY_C     = 17'd4640;
  localparam logic [16:0] X_ONE      = 17'd65536;
  localparam logic [16:0] SINE_MAX   = 17'd32767;
  localparam logic [16:0] FADE_BASE  = 17'd16384;
  localparam logic [16:0] FADE_UNITY = 17'd65536;
  localparam logic [5:0]  GAIN_NUM   = 6'd51;
  localparam logic [5:0]  GAIN_DEN   = 6'd50;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_MULS  = 5'b00100,
    ST_MDIV  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    UC_X1SQ, UC_X1C, UC_X1P1, UC_X1P2,
    UC_X3SQ, UC_X3C, UC_X3P1, UC_X3P2,
    UC_VOLSQ, UC_GAIN, UC_SG, UC_FE,
    UC_NLO, UC_NHI, UC_DEN, UC_DIV
  } uop_t;

endpackage

>>> sv/htse_mul.sv
// Shared unsigned multiplier with a registered product.
module htse_mul (
  input  logic                           clk,
  input  logic [htse_pkg::MUL_W-1:0]     mul_a,
  input  logic [htse_pkg::MUL_W-1:0]     mul_b,
  output logic [2*htse_pkg::MUL_W-1:0]   prod_r
);
  import htse_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

>>> sv/htse_div.sv
// Iterative restoring divider producing two quotient bits per cycle.
module htse_div #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int ITER  = (DVD_W + 1) / 2;
  localparam int PAD_W = 2 * ITER;
  localparam int CNT_W = $clog2(ITER + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PAD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   trial0, trial1;
  logic [DVS_W-1:0] rem0, rem1;
  logic [PAD_W-1:0] quo0, quo1;
  logic             ge0, ge1;

  always_comb begin
    trial0 = {rem_r, quo_r[PAD_W-1]};
    ge0    = trial0 >= {1'b0, dvs_r};
    rem0   = ge0 ? DVS_W'(trial0 - {1'b0, dvs_r}) : trial0[DVS_W-1:0];
    quo0   = {quo_r[PAD_W-2:0], ge0};
    trial1 = {rem0, quo0[PAD_W-1]};
    ge1    = trial1 >= {1'b0, dvs_r};
    rem1   = ge1 ? DVS_W'(trial1 - {1'b0, dvs_r}) : trial1[DVS_W-1:0];
    quo1   = {quo0[PAD_W-2:0], ge1};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= PAD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo1;
      rem_r <= rem1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[DVD_W-1:0];

endmodule

>>> sv/harmonic_tone_synth_envelope_core.sv
// Top level of the harmonic tone synthesiser: sequencer, datapath registers and ports.
// An audible item reaches the output register through one set-up state, sixteen multiplier
// steps, sixteen divider passes, a state that collects the quotient and one that loads the result,
// which waits while an earlier sample is still untaken. An item with a zero step goes straight
// to the loading state. One item is in work at a time: the next is taken once one is loaded.
// Reset (rst_n low at a clock edge) clears phase, fade counter and control; volume 60, ramp 110.
module harmonic_tone_synth_envelope_core #(
  parameter int PHASE_BITS     = 24,
  parameter int SINE_ADDR_BITS = 10,
  parameter int FADE_SAMPLES   = 176400
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tone_step [22:0], note_position [43:23], note_length [64:44], zero [71:65]
  input  logic [htse_pkg::TDATA_W-1:0]         in_tdata,
  // fade_restart
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // sample [15:0]
  output logic signed [htse_pkg::SAMPLE_W-1:0] out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [htse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htse_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import htse_pkg::*;

  localparam int FADE_W  = $clog2(FADE_SAMPLES + 1);
  localparam int FR_W    = FADE_W + 1;
  localparam int FQ_STEP = FADE_SPAN / FADE_SAMPLES;
  localparam int FR_STEP = FADE_SPAN % FADE_SAMPLES;
  localparam int DVD_W   = 31;
  localparam int DVS_W   = 16;
  localparam int QB      = SINE_ADDR_BITS - 2;

  function automatic logic [16:0] quarter_x(input logic [SINE_ADDR_BITS-1:0] a);
    logic [16:0] f;
    f = 17'(a[QB-1:0]) << (16 - QB);
    return a[QB] ? (X_ONE - f) : f;
  endfunction

  state_t st_r, st_nxt;
  uop_t   uc_r, uc_nxt;

  logic [VOL_W-1:0]    vol_r;
  logic                fade_en_r;
  logic [RAMP_W-1:0]   ramp_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [FADE_W-1:0]   fade_cnt_r;
  logic [15:0]         fade_q_r;
  logic [FADE_W-1:0]   fade_rem_r;
  logic [POS_W-1:0]    pos_r, len_r;
  logic                out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic signed [SAMPLE_W-1:0] res_r;

  logic [16:0]  x2_r;
  logic signed [15:0] sin1_r, sin3_r;
  logic [17:0]  sabs_r;
  logic         neg_r;
  logic [36:0]  h_r;
  logic [25:0]  f_r;
  logic [58:0]  lo_r;
  logic [30:0]  q_r;
  logic [16:0]  fade_r;
  logic [RAMP_W-1:0] env_num_r, env_den_r;

  logic                accept;
  logic [STEP_W-1:0]   in_step;
  logic [FADE_W-1:0]   cnt_now;
  logic [15:0]         fq_now;
  logic [FADE_W-1:0]   fr_now;
  logic [FR_W-1:0]     fr_sum;
  logic                fr_wrap;
  logic [PHASE_BITS-1:0] phase3;
  logic [SINE_ADDR_BITS-1:0] addr1, addr3;
  logic [16:0]  x1, x3;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_prod;
  logic [16:0]  p1, p2;
  logic [14:0]  sine_mag;
  logic signed [15:0] sine1_val, sine3_val;
  logic [18:0]  s_sum;
  logic [63:0]  n_full;
  logic [VOL_W-1:0]  vol_sat;
  logic [POS_W-1:0]  len_left;
  logic [RAMP_W-1:0] env_num, env_den;
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [DVS_W-1:0]  div_dvs;
  logic [15:0]       res_mag;

  assign in_step   = in_tdata[STEP_W-1:0];
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The fade quotient and remainder follow the counter, so the fade needs no division.
  assign cnt_now = in_tuser ? '0 : fade_cnt_r;
  assign fq_now  = in_tuser ? '0 : fade_q_r;
  assign fr_now  = in_tuser ? '0 : fade_rem_r;
  assign fr_sum  = {1'b0, fr_now} + FR_W'(FR_STEP);
  assign fr_wrap = fr_sum >= FR_W'(FADE_SAMPLES);

  assign phase3 = phase_r + {phase_r[PHASE_BITS-2:0], 1'b0};
  assign addr1  = phase_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign addr3  = phase3[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign x1     = quarter_x(addr1);
  assign x3     = quarter_x(addr3);

  assign p1 = POLY_B - mul_prod[32:16];
  assign p2 = POLY_A - mul_prod[32:16];
  assign sine_mag  = (mul_prod[33:17] > SINE_MAX) ? SINE_MAX[14:0] : mul_prod[31:17];
  assign sine1_val = addr1[SINE_ADDR_BITS-1] ? -$signed({1'b0, sine_mag})
                                             : $signed({1'b0, sine_mag});
  assign sine3_val = addr3[SINE_ADDR_BITS-1] ? -$signed({1'b0, sine_mag})
                                             : $signed({1'b0, sine_mag});
  assign s_sum  = {sin1_r[15], sin1_r, 2'b00} + {{3{sin3_r[15]}}, sin3_r};
  assign n_full = 64'(lo_r) + {mul_prod[31:0], 32'd0};
  assign vol_sat = (vol_r > VOL_MAX) ? VOL_MAX : vol_r;
  assign res_mag = {1'b0, div_quo[14:0]};

  assign div_start = (st_r == ST_MULS) && (uc_r == UC_DIV);
  assign div_dvd   = q_r;
  assign div_dvs   = mul_prod[15:0];

  always_comb begin
    len_left = len_r - pos_r;
    env_num  = RAMP_W'(1);
    env_den  = RAMP_W'(1);
    if (pos_r >= len_r) begin
      env_num = '0;
    end else if (ramp_r != '0) begin
      env_den = ramp_r;
      if (pos_r < POS_W'(ramp_r)) begin
        env_num = pos_r[RAMP_W-1:0];
      end else if (len_left < POS_W'(ramp_r)) begin
        env_num = len_left[RAMP_W-1:0];
      end else begin
        env_num = ramp_r;
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uc_r)
      UC_X1SQ:  begin mul_a = MUL_W'(x1);               mul_b = MUL_W'(x1); end
      UC_X1C:   begin mul_a = MUL_W'(mul_prod[32:16]);  mul_b = MUL_W'(POLY_C); end
      UC_X1P1:  begin mul_a = MUL_W'(x2_r);             mul_b = MUL_W'(p1); end
      UC_X1P2:  begin mul_a = MUL_W'(x1);               mul_b = MUL_W'(p2); end
      UC_X3SQ:  begin mul_a = MUL_W'(x3);               mul_b = MUL_W'(x3); end
      UC_X3C:   begin mul_a = MUL_W'(mul_prod[32:16]);  mul_b = MUL_W'(POLY_C); end
      UC_X3P1:  begin mul_a = MUL_W'(x2_r);             mul_b = MUL_W'(p1); end
      UC_X3P2:  begin mul_a = MUL_W'(x3);               mul_b = MUL_W'(p2); end
      UC_VOLSQ: begin mul_a = MUL_W'(vol_sat);          mul_b = MUL_W'(vol_sat); end
      UC_GAIN:  begin mul_a = MUL_W'(mul_prod[13:0]);   mul_b = MUL_W'(GAIN_NUM); end
      UC_SG:    begin mul_a = MUL_W'(sabs_r);           mul_b = MUL_W'(mul_prod[18:0]); end
      UC_FE:    begin mul_a = MUL_W'(fade_r);           mul_b = MUL_W'(env_num_r); end
      UC_NLO:   begin mul_a = h_r[31:0];                mul_b = MUL_W'(mul_prod[25:0]); end
      UC_NHI:   begin mul_a = MUL_W'(h_r[36:32]);       mul_b = MUL_W'(f_r); end
      UC_DEN:   begin mul_a = MUL_W'(env_den_r);        mul_b = MUL_W'(GAIN_DEN); end
      default:  begin mul_a = '0;                       mul_b = '0; end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    uc_nxt        = uc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt = (in_step == '0) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        uc_nxt = UC_X1SQ;
        st_nxt = ST_MULS;
      end
      ST_MULS: begin
        uc_nxt = uop_t'(uc_r + 1'b1);
        if (uc_r == UC_DIV) begin
          st_nxt = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      uc_r        <= UC_X1SQ;
      out_valid_r <= 1'b0;
      vol_r       <= VOL_RESET;
      fade_en_r   <= 1'b0;
      ramp_r      <= RAMP_RESET;
      phase_r     <= '0;
      fade_cnt_r  <= '0;
      fade_q_r    <= '0;
      fade_rem_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      uc_r        <= uc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VOLUME:   vol_r     <= cfg_data[VOL_W-1:0];
          CFG_FADE_EN:  fade_en_r <= cfg_data[0];
          CFG_RAMP_LEN: ramp_r    <= cfg_data[RAMP_W-1:0];
          default:      ;
        endcase
      end
      if (accept) begin
        if (in_step != '0) begin
          phase_r <= phase_r + PHASE_BITS'(in_step);
        end
        if (cnt_now < FADE_W'(FADE_SAMPLES)) begin
          fade_cnt_r <= cnt_now + 1'b1;
          fade_q_r   <= fr_wrap ? fq_now + 16'(FQ_STEP + 1) : fq_now + 16'(FQ_STEP);
          fade_rem_r <= fr_wrap ? FADE_W'(fr_sum - FR_W'(FADE_SAMPLES)) : fr_sum[FADE_W-1:0];
        end else begin
          fade_cnt_r <= cnt_now;
          fade_q_r   <= fq_now;
          fade_rem_r <= fr_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r  <= in_tdata[STEP_W +: POS_W];
      len_r  <= in_tdata[STEP_W+POS_W +: POS_W];
      fade_r <= fade_en_r ? FADE_BASE + 17'(fq_now) : FADE_UNITY;
      res_r  <= '0;
    end
    if (st_r == ST_SETUP) begin
      env_num_r <= env_num;
      env_den_r <= env_den;
    end
    if (st_r == ST_MDIV && div_done) begin
      res_r <= neg_r ? $signed(16'd0 - res_mag) : $signed(res_mag);
    end
    if (st_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
    end
    if (st_r == ST_MULS) begin
      case (uc_r)
        UC_X1C, UC_X3C: x2_r <= mul_prod[32:16];
        UC_X3SQ:        sin1_r <= sine1_val;
        UC_VOLSQ:       sin3_r <= sine3_val;
        UC_GAIN: begin
          neg_r  <= s_sum[18];
          sabs_r <= s_sum[18] ? 18'(19'd0 - s_sum) : s_sum[17:0];
        end
        UC_FE:          h_r  <= mul_prod[36:0];
        UC_NLO:         f_r  <= mul_prod[25:0];
        UC_NHI:         lo_r <= mul_prod[58:0];
        UC_DEN:         q_r  <= n_full[63:33];
        default:        ;
      endcase
    end
  end

  htse_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (mul_prod)
  );

  htse_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  a_silent_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_step == '0) |=> $stable(phase_r))
    else $error("Phase moved on an item with a zero step.");

  a_fade_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    fade_cnt_r <= FADE_W'(FADE_SAMPLES))
    else $error("Fade counter ran past its limit.");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_MDIV))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MULS && uc_r != UC_DIV) |=>
      (st_r == ST_MULS && uc_r == uop_t'($past(uc_r) + 1'b1)))
    else $error("Multiplier step sequence broke off.");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && out_valid_r && !out_tready) |=> (st_r == ST_DONE))
    else $error("A finished item overwrote a result not yet taken.");

endmodule

>>> test/harmonic_tone_synth_envelope_core_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every output sample of the tone synthesiser core and compares it.
module harmonic_tone_synth_envelope_core_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [htse_pkg::TDATA_W-1:0]         in_tdata,
  input  logic                                 in_tuser,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic signed [htse_pkg::SAMPLE_W-1:0] out_tdata,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [htse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htse_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   samples_pending
);
  import htse_pkg::*;

  localparam int PHASE_W      = 24;
  localparam int ADDR_W       = 10;
  localparam int FADE_SAMPLES = 176400;

  logic [PHASE_W-1:0]       phase_acc;
  logic [17:0]              fade_cnt;
  logic [VOL_W-1:0]         vol_reg;
  logic                     fade_on;
  logic [RAMP_W-1:0]        ramp_reg;
  logic signed [SAMPLE_W-1:0] expected_samples[$];
  int                       samples_seen;

  initial begin
    mismatches   = 0;
    samples_seen = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: sample %0d: %s", $time, samples_seen, what);
    mismatches++;
  endtask

  function automatic longint sine_q15(input logic [ADDR_W-1:0] addr);
    longint unsigned f, x, x2, p, r;
    f  = {56'd0, addr[ADDR_W-3:0]} << (16 - (ADDR_W - 2));
    x  = addr[ADDR_W-2] ? X_ONE - f : f;
    x2 = (x * x) >> 16;
    p  = POLY_B - ((x2 * POLY_C) >> 16);
    p  = POLY_A - ((x2 * p) >> 16);
    r  = ((x * p) >> 16) >> 1;
    if (r > SINE_MAX) r = SINE_MAX;
    return addr[ADDR_W-1] ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] shaped_sample(input logic [PHASE_W-1:0] ph,
                                                               input logic [17:0] cnt,
                                                               input logic [POS_W-1:0] pos,
                                                               input logic [POS_W-1:0] len);
    logic [PHASE_W-1:0] ph3;
    longint             mix;
    longint unsigned    vol, fade, num, den, mag;
    ph3  = ph * 24'd3;
    mix  = 4 * sine_q15(ph[PHASE_W-1 -: ADDR_W]) + sine_q15(ph3[PHASE_W-1 -: ADDR_W]);
    vol  = (vol_reg > VOL_MAX) ? VOL_MAX : vol_reg;
    fade = FADE_UNITY;
    if (fade_on) fade = FADE_BASE + (64'd49152 * cnt) / FADE_SAMPLES;
    num = 1;
    den = 1;
    if (pos >= len) begin
      num = 0;
    end else if (ramp_reg != 0) begin
      den = ramp_reg;
      if (pos < ramp_reg) num = pos;
      else if (len - pos < ramp_reg) num = len - pos;
      else num = ramp_reg;
    end
    mag = (mix < 0) ? -mix : mix;
    mag = mag * GAIN_NUM * vol * vol * fade * num;
    mag = mag / (GAIN_DEN * (64'd1 << 33) * den);
    return (mix < 0) ? -$signed(mag[SAMPLE_W-1:0]) : $signed(mag[SAMPLE_W-1:0]);
  endfunction

  always @(posedge clk) begin : track
    logic signed [SAMPLE_W-1:0] want;
    logic [17:0]                cnt;
    logic [STEP_W-1:0]          step;
    if (!rst_n) begin
      phase_acc = '0;
      fade_cnt  = '0;
      vol_reg   = VOL_RESET;
      fade_on   = 1'b0;
      ramp_reg  = RAMP_RESET;
      expected_samples.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("unexpected sample %0d", out_tdata));
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want)
            flag_mismatch($sformatf("got %0d, expected %0d", out_tdata, want));
        end
        samples_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VOLUME:   vol_reg  = cfg_data[VOL_W-1:0];
          CFG_FADE_EN:  fade_on  = cfg_data[0];
          CFG_RAMP_LEN: ramp_reg = cfg_data[RAMP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) fade_cnt = '0;
        cnt = fade_cnt;
        if (fade_cnt < FADE_SAMPLES) fade_cnt++;
        step = in_tdata[STEP_W-1:0];
        want = '0;
        if (step != 0) begin
          phase_acc = phase_acc + step;
          want = shaped_sample(phase_acc, cnt, in_tdata[STEP_W +: POS_W],
                               in_tdata[STEP_W+POS_W +: POS_W]);
        end
        expected_samples.push_back(want);
      end
    end
    samples_pending = expected_samples.size();
  end

endmodule

>>> test/harmonic_tone_synth_envelope_core_tb.sv
`timescale 1ns / 100ps
// Testbench top: plays notes and register settings into the tone synthesiser core.
module harmonic_tone_synth_envelope_core_tb;
  import htse_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LONG_HOLD    = 400;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [TDATA_W-1:0]         in_tdata   = '0;
  logic                       in_tuser   = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_tdata;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index  = '0;
  logic [CFG_DATA_W-1:0]      cfg_data   = '0;

  int          mismatches;
  int          samples_pending;
  bit          idle_on       = 1'b1;
  int          items_sent    = 0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  logic [RAMP_W-1:0] ramp_now = RAMP_RESET;

  harmonic_tone_synth_envelope_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  harmonic_tone_synth_envelope_core_checker sample_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .samples_pending (samples_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("harmonic_tone_synth_envelope_core_tb: errors");
    $finish;
  end

  initial begin : sample_sink
    int n;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        n = $urandom_range(1, 8);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [STEP_W-1:0] step, input logic [POS_W-1:0] pos,
                           input logic [POS_W-1:0] len, input logic restart);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(TDATA_W - STEP_W - 2 * POS_W){1'b0}}, len, pos, step};
    in_tuser  = restart;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (samples_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [VOL_W-1:0] vol, input logic fade,
                          input logic [RAMP_W-1:0] ramp);
    logic [2:0]            vol_pad;
    logic [8:0]            fade_pad;
    logic [CFG_DATA_W-1:0] junk;
    vol_pad  = 3'($urandom);
    fade_pad = 9'($urandom);
    junk     = CFG_DATA_W'($urandom);
    wait_drained();
    write_reg(CFG_VOLUME, {vol_pad, vol});
    write_reg(CFG_FADE_EN, {fade_pad, fade});
    write_reg(CFG_RAMP_LEN, ramp);
    write_reg(CFG_UNUSED, junk);
    cfg_valid = 1'b0;
    ramp_now  = ramp;
  endtask

  // Short notes are played whole; longer ones around the note ends, the ramp edges and one random point.
  task automatic play_note(input logic [STEP_W-1:0] step, input int len, input logic restart);
    int marks[12];
    int r;
    r = int'(ramp_now);
    if (len <= 40) begin
      for (int p = 0; p < len; p++)
        send_item(step, POS_W'(p), POS_W'(len), restart && p == 0);
    end else begin
      marks = '{0, 1, 2, r - 1, r, r + 1, $urandom_range(3, len - 3),
                len - r - 1, len - r, len - r + 1, len - 2, len - 1};
      foreach (marks[i])
        if (marks[i] >= 0 && marks[i] < len)
          send_item(step, POS_W'(marks[i]), POS_W'(len), restart && i == 0);
    end
    if ($urandom_range(0, 3) == 0) send_item(step, POS_W'(len), POS_W'(len), 1'b0);
  endtask

  task automatic random_phase(input int n);
    int                start;
    int                len;
    logic [STEP_W-1:0] step;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0:       len = $urandom_range(1, 40);
          1:       len = $urandom_range(41, 4000);
          2:       len = $urandom_range(41, 2097151);
          default: len = $urandom_range(200, 12000);
        endcase
        case ($urandom_range(0, 5))
          0:       step = '0;
          1:       step = STEP_W'($urandom_range(1, 255));
          2:       step = STEP_W'($urandom);
          default: step = STEP_W'($urandom_range(70000, 3200000));
        endcase
        play_note(step, len, $urandom_range(0, 11) == 0);
      end else begin
        send_item(STEP_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send_item(0, 50, 1000, 1'b1);
    send_item(1, 0, 1000, 1'b0);
    send_item(23'h7FFFFF, 1, 1000, 1'b0);
    send_item(23'h400000, 55, 1000, 1'b0);
    send_item(1234567, 500, 1000, 1'b0);
    send_item(1234567, 999, 1000, 1'b0);
    send_item(1234567, 1000, 1000, 1'b0);
    send_item(1234567, 5, 0, 1'b0);
    send_item(23'h7FFFFF, 21'h1FFFFF, 21'h1FFFFF, 1'b0);
    send_item(23'h7FFFFF, 21'h1FFFFE, 21'h1FFFFF, 1'b0);
    send_item(333333, 109, 21'h1FFFFF, 1'b0);
    send_item(333333, 110, 21'h1FFFFF, 1'b0);
    send_item(0, 0, 1, 1'b1);

    set_mode(100, 1'b1, 1023);
    send_item(765432, 0, 2000, 1'b1);
    send_item(765432, 1022, 2000, 1'b0);
    send_item(765432, 1023, 2000, 1'b0);
    send_item(23'h7FFFFF, 1500, 3000, 1'b0);

    set_mode(127, 1'b0, 0);
    send_item(444444, 0, 10, 1'b0);
    send_item(444444, 9, 10, 1'b0);
    send_item(444444, 10, 10, 1'b0);
    send_item(23'h7FFFFF, 3, 10, 1'b0);

    set_mode(0, 1'b1, 1);
    send_item(23'h7FFFFF, 5, 10, 1'b1);
    send_item(2222222, 0, 10, 1'b0);

    set_mode(100, 1'b1, 1023);
    random_phase(185);
    set_mode(0, 1'b0, 1);
    hold_requests++;
    random_phase(185);
    set_mode(127, 1'b1, 0);
    random_phase(185);
    set_mode(VOL_W'($urandom_range(0, 100)), 1'($urandom_range(0, 1)),
             RAMP_W'($urandom_range(1, 1023)));
    random_phase(185);
    set_mode(VOL_W'($urandom_range(0, 100)), 1'($urandom_range(0, 1)),
             RAMP_W'($urandom_range(1, 1023)));
    random_phase(185);
    idle_on = 1'b0;
    set_mode(VOL_W'($urandom_range(0, 100)), 1'($urandom_range(0, 1)),
             RAMP_W'($urandom_range(1, 1023)));
    random_phase(185);

    in_tvalid = 1'b0;
    for (k = 0; k < 200000 && samples_pending != 0; k++) @(negedge clk);
    repeat (64) @(negedge clk);
    if (samples_pending != 0) $display("%0d expected samples never arrived", samples_pending);
    if (mismatches == 0 && samples_pending == 0) begin
      $display("harmonic_tone_synth_envelope_core_tb: clean");
    end else begin
      $display("harmonic_tone_synth_envelope_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/htse_pkg.sv
sv/htse_mul.sv
sv/htse_div.sv
sv/harmonic_tone_synth_envelope_core.sv
test/harmonic_tone_synth_envelope_core_checker.sv
test/harmonic_tone_synth_envelope_core_tb.sv
